/* design/afs_pkg.sv */
package afs_pkg;

    localparam int MAX_SAMPLES_DEF  = 64;
    localparam int ALLELE_SLOTS_DEF = 1024;

    localparam int VALUE_W = 11;
    localparam int BIN_W   = 7;

    typedef struct packed {
        logic signed [VALUE_W-1:0] allele_value;
        logic                      last_item;
    } sample_t;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic [BIN_W-1:0] bin_value;
        logic             last_bin;
        logic             overflow;
    } bin_t;

    typedef struct packed {
        logic clr_write;
        logic accept;
        logic upd;
        logic dl_rd;
        logic tc_rd_walk;
        logic bin_rd_walk;
        logic bin_inc;
        logic out_rd;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic item_ok;
        logic item_last;
        logic last_q;
        logic walk_done;
        logic walk_empty;
        logic out_free;
        logic out_final;
    } dp_status_t;

endpackage

/* design/afs_stream_if.sv */
interface afs_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

/* design/afs_ram.sv */
module afs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/afs_ctrl.sv */
module afs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  afs_pkg::dp_status_t    status,
    output afs_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_UPDATE = 9'b000000100,
        ST_W_DL   = 9'b000001000,
        ST_W_TC   = 9'b000010000,
        ST_W_BIN  = 9'b000100000,
        ST_W_INC  = 9'b001000000,
        ST_O_RD   = 9'b010000000,
        ST_O_LOAD = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (status.item_ok)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else if (status.item_last)
                    begin
                        state_next = status.walk_empty ? ST_O_RD : ST_W_DL;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.upd    = 1'b1;
                state_next = status.last_q ? ST_W_DL : ST_IDLE;
            end
            ST_W_DL:
            begin
                cmd.dl_rd  = 1'b1;
                state_next = ST_W_TC;
            end
            ST_W_TC:
            begin
                cmd.tc_rd_walk = 1'b1;
                state_next     = ST_W_BIN;
            end
            ST_W_BIN:
            begin
                cmd.bin_rd_walk = 1'b1;
                state_next      = ST_W_INC;
            end
            ST_W_INC:
            begin
                cmd.bin_inc = 1'b1;
                state_next  = status.walk_done ? ST_O_RD : ST_W_DL;
            end
            ST_O_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_O_LOAD;
            end
            ST_O_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.out_final ? ST_IDLE : ST_O_RD;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* design/afs_datapath.sv */
module afs_datapath #(
    parameter int MAX_SAMPLES  = afs_pkg::MAX_SAMPLES_DEF,
    parameter int ALLELE_SLOTS = afs_pkg::ALLELE_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  afs_pkg::ctrl_cmd_t  cmd,
    output afs_pkg::dp_status_t status,
    input  afs_pkg::sample_t    in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output afs_pkg::bin_t       out_data
);

    localparam int SW    = $clog2(ALLELE_SLOTS);
    localparam int BW    = $clog2(MAX_SAMPLES);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int CLR_N = (ALLELE_SLOTS > MAX_SAMPLES) ? ALLELE_SLOTS : MAX_SAMPLES;
    localparam int CW    = $clog2(CLR_N);

    logic [CW-1:0]     clr_cnt_reg;
    logic [NW-1:0]     items_reg;
    logic [NW-1:0]     total_reg;
    logic              dropped_reg;
    logic [BW-1:0]     walk_idx_reg;
    logic [BW-1:0]     kout_reg;
    logic              out_valid_reg;
    logic [SW-1:0]     slot_reg;
    logic              last_reg;
    logic [BW-1:0]     bin_addr_reg;
    afs_pkg::bin_t     out_data_reg;

    logic signed [11:0] slot_s;
    logic [31:0]        slot_wide;
    logic               slot_in_range;
    logic [SW-1:0]      slot_addr;
    logic [NW-1:0]      nout;
    logic [NW-1:0]      kout_plus;
    logic [BW-1:0]      c_minus;
    logic               out_final;

    logic              tc_we;
    logic [SW-1:0]     tc_waddr;
    logic [NW-1:0]     tc_wdata;
    logic              tc_re;
    logic [SW-1:0]     tc_raddr;
    logic [NW-1:0]     tc_rdata;

    logic              dl_we;
    logic [SW-1:0]     dl_rdata;

    logic              bin_we;
    logic [BW-1:0]     bin_waddr;
    logic [NW-1:0]     bin_wdata;
    logic              bin_re;
    logic [BW-1:0]     bin_raddr;
    logic [NW-1:0]     bin_rdata;

    // Table slot is the allele code plus one, so the missing code -1 lands in slot 0.
    assign slot_s        = $signed({in_data.allele_value[afs_pkg::VALUE_W-1],
                                    in_data.allele_value}) + 12'sd1;
    assign slot_wide     = {21'b0, slot_s[10:0]};
    assign slot_in_range = !slot_s[11] && (slot_wide < 32'(ALLELE_SLOTS));
    assign slot_addr     = slot_wide[SW-1:0];

    assign nout      = (items_reg == '0) ? NW'(1) : items_reg;
    assign kout_plus = NW'(kout_reg) + NW'(1);
    assign out_final = (kout_plus == nout);
    assign c_minus   = BW'(tc_rdata - NW'(1));

    assign status.clr_done   = (clr_cnt_reg == CW'(CLR_N - 1));
    assign status.item_ok    = slot_in_range && (items_reg < NW'(MAX_SAMPLES));
    assign status.item_last  = in_data.last_item;
    assign status.last_q     = last_reg;
    assign status.walk_done  = ((NW'(walk_idx_reg) + NW'(1)) == total_reg);
    assign status.walk_empty = (total_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.out_final  = out_final;

    always_comb
    begin
        tc_we    = 1'b0;
        tc_waddr = slot_reg;
        tc_wdata = '0;
        if (cmd.clr_write)
        begin
            tc_we    = ({1'b0, clr_cnt_reg} < (CW + 1)'(ALLELE_SLOTS));
            tc_waddr = clr_cnt_reg[SW-1:0];
        end
        else if (cmd.upd)
        begin
            tc_we    = 1'b1;
            tc_wdata = tc_rdata + NW'(1);
        end
        else if (cmd.bin_rd_walk)
        begin
            tc_we = 1'b1;
        end
    end

    assign tc_re    = cmd.accept || cmd.tc_rd_walk;
    assign tc_raddr = cmd.tc_rd_walk ? dl_rdata : slot_addr;

    assign dl_we = cmd.upd && (tc_rdata == '0);

    always_comb
    begin
        bin_we    = 1'b0;
        bin_waddr = kout_reg;
        bin_wdata = '0;
        if (cmd.clr_write)
        begin
            bin_we    = ({1'b0, clr_cnt_reg} < (CW + 1)'(MAX_SAMPLES));
            bin_waddr = clr_cnt_reg[BW-1:0];
        end
        else if (cmd.bin_inc)
        begin
            bin_we    = 1'b1;
            bin_waddr = bin_addr_reg;
            bin_wdata = bin_rdata + NW'(1);
        end
        else if (cmd.out_load)
        begin
            bin_we = 1'b1;
        end
    end

    assign bin_re    = cmd.bin_rd_walk || cmd.out_rd;
    assign bin_raddr = cmd.bin_rd_walk ? c_minus : kout_reg;

    afs_ram #(
        .WIDTH (NW),
        .DEPTH (ALLELE_SLOTS)
    ) u_type_counts (
        .clk   (clk),
        .we    (tc_we),
        .waddr (tc_waddr),
        .wdata (tc_wdata),
        .re    (tc_re),
        .raddr (tc_raddr),
        .rdata (tc_rdata)
    );

    afs_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SAMPLES)
    ) u_distinct_list (
        .clk   (clk),
        .we    (dl_we),
        .waddr (total_reg[BW-1:0]),
        .wdata (slot_reg),
        .re    (cmd.dl_rd),
        .raddr (walk_idx_reg),
        .rdata (dl_rdata)
    );

    afs_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_SAMPLES)
    ) u_spectrum_bins (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .re    (bin_re),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            items_reg     <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            walk_idx_reg  <= '0;
            kout_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (cmd.accept && !status.item_ok)
            begin
                dropped_reg <= 1'b1;
            end
            if (cmd.upd)
            begin
                items_reg <= items_reg + NW'(1);
                if (tc_rdata == '0)
                begin
                    total_reg <= total_reg + NW'(1);
                end
            end
            if (cmd.bin_inc)
            begin
                walk_idx_reg <= walk_idx_reg + BW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (out_final)
                begin
                    items_reg    <= '0;
                    total_reg    <= '0;
                    dropped_reg  <= 1'b0;
                    walk_idx_reg <= '0;
                    kout_reg     <= '0;
                end
                else
                begin
                    kout_reg <= kout_reg + BW'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            slot_reg <= slot_addr;
            last_reg <= in_data.last_item;
        end
        else if (cmd.tc_rd_walk)
        begin
            slot_reg <= dl_rdata;
        end
        if (cmd.bin_rd_walk)
        begin
            bin_addr_reg <= c_minus;
        end
        if (cmd.out_load)
        begin
            out_data_reg.bin_index <= afs_pkg::BIN_W'(kout_plus);
            out_data_reg.bin_value <= afs_pkg::BIN_W'(bin_rdata);
            out_data_reg.last_bin  <= out_final;
            out_data_reg.overflow  <= dropped_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* design/allele_frequency_spectrum_top.sv */
// Allele frequency spectrum counter.
// The samples channel takes one allele code per transfer, with last_item set on
// the final allele of a sample set. Each counted allele does a read-modify-write
// of the type count memory; a dropped allele leaves it unchanged.
// On the last allele the block walks the list of distinct alleles to build the
// spectrum in the bin memory, reading the list, the type count and the bin and
// then writing the incremented bin for each distinct allele. It then sends
// n transfers on the spectrum channel, one per bin from 1 to n, where n is the
// number of alleles counted. An empty set gives a single bin. Input is not taken
// while the spectrum is being built or sent, but the next set may start loading
// while the final bin still waits in the output register. A stalled receiver
// holds the current bin and pauses the sequence. After reset the block sweeps
// the type count and bin memories before taking input.
module allele_frequency_spectrum_top #(
    parameter int MAX_SAMPLES  = afs_pkg::MAX_SAMPLES_DEF,
    parameter int ALLELE_SLOTS = afs_pkg::ALLELE_SLOTS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    afs_stream_if.sink   samples,
    afs_stream_if.source spectrum
);

    afs_pkg::ctrl_cmd_t  cmd;
    afs_pkg::dp_status_t status;
    logic                in_ready;
    logic                out_valid;
    afs_pkg::bin_t       out_data;

    afs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    afs_datapath #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .ALLELE_SLOTS (ALLELE_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (samples.data),
        .out_ready (spectrum.ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign samples.ready  = in_ready;
    assign spectrum.valid = out_valid;
    assign spectrum.data  = out_data;

endmodule

/* design/afs_checker.sv */
module afs_checker #(
    parameter int MAX_SAMPLES = afs_pkg::MAX_SAMPLES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input afs_pkg::bin_t out_data
);

    logic                        xfer;
    logic [afs_pkg::BIN_W-1:0]   exp_idx_reg;
    logic                        mid_set_reg;
    logic                        ovf_reg;
    logic [2*afs_pkg::BIN_W-1:0] product;

    assign xfer    = out_valid && out_ready;
    assign product = (2*afs_pkg::BIN_W)'(out_data.bin_index) *
                     (2*afs_pkg::BIN_W)'(out_data.bin_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= afs_pkg::BIN_W'(1);
            mid_set_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (xfer)
        begin
            ovf_reg <= out_data.overflow;
            if (out_data.last_bin)
            begin
                exp_idx_reg <= afs_pkg::BIN_W'(1);
                mid_set_reg <= 1'b0;
            end
            else
            begin
                exp_idx_reg <= out_data.bin_index + afs_pkg::BIN_W'(1);
                mid_set_reg <= 1'b1;
            end
        end
    end

    // Bins of one set arrive in order, starting from one.
    a_bin_order: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> out_data.bin_index == exp_idx_reg)
        else $error("spectrum bin out of sequence");

    a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && mid_set_reg |-> out_data.overflow == ovf_reg)
        else $error("overflow flag changed within a set");

    // v alleles seen exactly k times account for k*v samples, never more than the limit.
    a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> product <= (2*afs_pkg::BIN_W)'(MAX_SAMPLES))
        else $error("spectrum bin exceeds sample count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled spectrum transfer changed");

endmodule

bind allele_frequency_spectrum_top afs_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_afs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (spectrum.valid),
    .out_ready (spectrum.ready),
    .out_data  (spectrum.data)
);

/* tb/sv/afs_spectrum_compare.sv */
`timescale 1ns / 1ps

module afs_spectrum_compare
    import afs_pkg::*;
#(
    parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
    parameter int ALLELE_SLOTS = ALLELE_SLOTS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    afs_stream_if samples,
    afs_stream_if spectrum,
    output int    fail_count,
    output int    pending
);

    localparam int SLOT_W = $clog2(ALLELE_SLOTS);

    logic [BIN_W-1:0]  allele_tally [ALLELE_SLOTS];
    logic [SLOT_W-1:0] first_seen [MAX_SAMPLES];
    int                distinct_seen;
    int                alleles_held;
    bit                any_dropped;
    bin_t              bins_due [$];
    int                fails = 0;

    task automatic tally_allele(input sample_t s);
        int               code;
        int               slot;
        int               c;
        logic [BIN_W-1:0] spectrum_acc [MAX_SAMPLES];
        bin_t             b;
        code = $signed(s.allele_value);
        slot = code + 1;
        if (slot < 0 || slot >= ALLELE_SLOTS || alleles_held >= MAX_SAMPLES)
        begin
            any_dropped = 1'b1;
        end
        else
        begin
            if (allele_tally[slot] == '0 && distinct_seen < MAX_SAMPLES)
            begin
                first_seen[distinct_seen] = SLOT_W'(slot);
                distinct_seen++;
            end
            allele_tally[slot] = allele_tally[slot] + 1'b1;
            alleles_held++;
        end
        if (!s.last_item)
        begin
            return;
        end
        for (int i = 0; i < MAX_SAMPLES; i++)
        begin
            spectrum_acc[i] = '0;
        end
        for (int i = 0; i < distinct_seen; i++)
        begin
            c = allele_tally[first_seen[i]];
            if (c >= 1 && c <= MAX_SAMPLES)
            begin
                spectrum_acc[c-1] = spectrum_acc[c-1] + 1'b1;
            end
            allele_tally[first_seen[i]] = '0;
        end
        if (alleles_held == 0)
        begin
            b.bin_index = BIN_W'(1);
            b.bin_value = '0;
            b.last_bin  = 1'b1;
            b.overflow  = any_dropped;
            bins_due = {bins_due, b};
        end
        else
        begin
            for (int i = 0; i < alleles_held; i++)
            begin
                b.bin_index = BIN_W'(i + 1);
                b.bin_value = spectrum_acc[i];
                b.last_bin  = (i + 1 == alleles_held);
                b.overflow  = any_dropped;
                bins_due = {bins_due, b};
            end
        end
        distinct_seen = 0;
        alleles_held  = 0;
        any_dropped   = 1'b0;
    endtask

    always @(posedge clk)
    begin
        bin_t want;
        bin_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < ALLELE_SLOTS; i++)
            begin
                allele_tally[i] = '0;
            end
            distinct_seen = 0;
            alleles_held  = 0;
            any_dropped   = 1'b0;
            bins_due.delete();
        end
        else
        begin
            if (spectrum.valid && spectrum.ready)
            begin
                got = spectrum.data;
                if (bins_due.size() == 0)
                begin
                    $error("unexpected spectrum transfer: bin_index %0d bin_value %0d",
                           got.bin_index, got.bin_value);
                    fails++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (got.bin_index !== want.bin_index)
                    begin
                        $error("bin_index: expected %0d, actual %0d",
                               want.bin_index, got.bin_index);
                        fails++;
                    end
                    if (got.bin_value !== want.bin_value)
                    begin
                        $error("bin_value: expected %0d, actual %0d",
                               want.bin_value, got.bin_value);
                        fails++;
                    end
                    if (got.last_bin !== want.last_bin)
                    begin
                        $error("last_bin: expected %0d, actual %0d",
                               want.last_bin, got.last_bin);
                        fails++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, got.overflow);
                        fails++;
                    end
                end
            end
            if (samples.valid && samples.ready)
            begin
                tally_allele(samples.data);
            end
        end
        fail_count <= fails;
        pending    <= bins_due.size();
    end

endmodule

/* tb/sv/tb_allele_frequency_spectrum_top.sv */
`timescale 1ns / 1ps

module tb_allele_frequency_spectrum_top;

    import afs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 150;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    bit   quiet = 1'b0;

    afs_stream_if #(.payload_t(sample_t)) samples ();
    afs_stream_if #(.payload_t(bin_t))    spectrum ();

    always #1 clk = ~clk;

    allele_frequency_spectrum_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .spectrum (spectrum)
    );

    afs_spectrum_compare u_spectrum_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .spectrum   (spectrum),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 9);
        return (r < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic int pick_allele(input int base);
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
        begin
            return base + $urandom_range(0, 7);
        end
        if (r < 17)
        begin
            return $urandom_range(0, 2047) - 1024;
        end
        case ($urandom_range(0, 4))
            0:       return -1;
            1:       return 0;
            2:       return 1022;
            3:       return 1023;
            default: return -1024;
        endcase
    endfunction

    task automatic send_allele(input int code, input bit last);
        sample_t s;
        int      gap;
        s.allele_value = code[VALUE_W-1:0];
        s.last_item    = last;
        gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        if (gap > 0)
        begin
            samples.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.data  <= s;
        do @(posedge clk); while (!samples.ready);
    endtask

    initial
    begin
        spectrum.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                spectrum.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            spectrum.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((samples.valid && samples.ready) || (spectrum.valid && spectrum.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("allele_frequency_spectrum_top: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int sent;
        int len;
        int base;
        int set_no;
        samples.valid <= 1'b0;
        samples.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // An empty set whose only allele is dropped still yields one bin.
        send_allele(-2, 1'b1);

        send_allele(-1, 1'b0);
        send_allele(0, 1'b0);
        send_allele(0, 1'b0);
        send_allele(1022, 1'b0);
        send_allele(1022, 1'b0);
        send_allele(1022, 1'b0);
        send_allele(-1024, 1'b0);
        send_allele(1023, 1'b1);

        send_allele(7, 1'b0);
        send_allele(7, 1'b0);
        send_allele(7, 1'b0);
        send_allele(7, 1'b0);
        send_allele(300, 1'b1);

        send_allele(-1, 1'b1);

        send_allele(512, 1'b0);
        send_allele(513, 1'b0);
        send_allele(512, 1'b0);
        send_allele(513, 1'b0);
        send_allele(-1, 1'b1);

        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            quiet = (set_no % 5 == 3);
            if (set_no == 2)
            begin
                len = $urandom_range(64, 68);
            end
            else if (set_no == 7)
            begin
                len = $urandom_range(40, 63);
            end
            else
            begin
                len = $urandom_range(1, 10);
            end
            base = $urandom_range(0, 1015) - 1;
            for (int i = 0; i < len; i++)
            begin
                send_allele(pick_allele(base), i == len - 1);
            end
            sent += len;
            set_no++;
        end
        quiet = 1'b0;
        samples.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("allele_frequency_spectrum_top: match");
        end
        else
        begin
            $display("allele_frequency_spectrum_top: mismatch");
        end
        $finish;
    end

endmodule

/* allele_frequency_spectrum_top.f */
design/afs_pkg.sv
design/afs_stream_if.sv
design/afs_ram.sv
design/afs_ctrl.sv
design/afs_datapath.sv
design/allele_frequency_spectrum_top.sv
design/afs_checker.sv
tb/sv/afs_spectrum_compare.sv
tb/sv/tb_allele_frequency_spectrum_top.sv
